[sv/qpht_pkg.sv]
// Shared types and fixed constants of the quadratic probe hash table.
package qpht_pkg;

    localparam int TABLE_SIZE = 4096;
    localparam int SLOT_W     = $clog2(TABLE_SIZE);
    localparam int KEY_BYTES  = 6;
    localparam int KEY_W      = 8 * KEY_BYTES;
    localparam int STATE_W    = 2;
    localparam int ENTRY_W    = STATE_W + KEY_W;
    localparam int FAC_W      = $clog2(KEY_BYTES + 1);

    // Probe offset 3i + 7i^2 grows by 14i + 10 from probe i to probe i+1.
    localparam logic [SLOT_W-1:0] STEP_FIRST = SLOT_W'(10);
    localparam logic [SLOT_W-1:0] STEP_INC   = SLOT_W'(14);

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_FIND   = 2'd1,
        OP_DELETE = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        STATUS_OK   = 2'd0,
        STATUS_MISS = 2'd1,
        STATUS_FULL = 2'd2
    } status_t;

    typedef enum logic [STATE_W-1:0] {
        SLOT_EMPTY = 2'd0,
        SLOT_USED  = 2'd1,
        SLOT_DEL   = 2'd2
    } slot_state_t;

endpackage

[sv/qpht_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module qpht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

[sv/qpht_hash.sv]
// Home slot hash: one key byte a cycle, squared product accumulated modulo table size.
module qpht_hash (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [qpht_pkg::KEY_W-1:0]    key,
    output logic                          done,
    output logic [qpht_pkg::SLOT_W-1:0]   home
);
    import qpht_pkg::*;

    logic [KEY_W-1:0]    key_reg;
    logic [FAC_W-1:0]    fac_reg;
    logic                busy_reg;
    logic                prod_vld_reg;
    logic [SLOT_W-1:0]   prod_reg;
    logic [SLOT_W-1:0]   sum_reg;
    logic                done_reg;
    logic [7:0]          cur_byte;
    logic [SLOT_W-1:0]   prod_next;
    logic [2*SLOT_W-1:0] square;

    assign cur_byte  = key_reg[KEY_W-1 -: 8];
    assign prod_next = SLOT_W'(SLOT_W'(cur_byte) * SLOT_W'(fac_reg));
    assign square    = prod_reg * prod_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg     <= 1'b0;
            prod_vld_reg <= 1'b0;
            done_reg     <= 1'b0;
        end else if (start) begin
            key_reg      <= key;
            fac_reg      <= FAC_W'(1);
            busy_reg     <= 1'b1;
            prod_vld_reg <= 1'b0;
            sum_reg      <= '0;
            done_reg     <= 1'b0;
        end else begin
            // Last product still in flight once busy drops: finish on it.
            done_reg <= prod_vld_reg && !busy_reg;
            if (busy_reg) begin
                prod_reg     <= prod_next;
                prod_vld_reg <= 1'b1;
                key_reg      <= key_reg << 8;
                fac_reg      <= fac_reg + FAC_W'(1);
                if (fac_reg == FAC_W'(KEY_BYTES)) begin
                    busy_reg <= 1'b0;
                end
            end else begin
                prod_vld_reg <= 1'b0;
            end
            if (prod_vld_reg) begin
                sum_reg <= sum_reg + square[SLOT_W-1:0];
            end
        end
    end

    assign done = done_reg;
    assign home = sum_reg;

endmodule

[sv/quadratic_probe_hash_table.sv]
// Top level of the open-addressed hash table with quadratic probing and tombstones.
//
// Open-addressed table of 4096 slots holding six-byte keys. Each slot keeps a
// two-bit state (empty, used, deleted) and its key in one 50-bit wide
// synchronous RAM. Insert and find first hash the key: one key byte per cycle,
// each byte times its position plus one, squared, summed modulo 4096. The
// probe walk then visits home + 3i + 7i^2 for i = 0 .. MAX_PROBES-1, one RAM
// read per cycle: the read issued in one cycle is checked in the next, and the
// check issues the read of the next probe directly. Insert claims the first
// slot that is not used (no duplicate check) and fails with status 2 after
// MAX_PROBES used slots, then reporting the last slot probed. Find stops at the
// first empty slot, steps over tombstones and reports the matching slot, or
// status 1 with slot 0. Delete writes a tombstone into the given slot without
// looking at it; an unused op code returns status 1 with slot 0. An insert or
// find takes 1 up to MAX_PROBES probes. One item is in work at a time, but a
// new item can be accepted while the previous result still waits in the output
// register. After reset a clearing pass writes every slot empty, one slot a
// cycle, and s_ready stays low until it ends.
module quadratic_probe_hash_table #(
    parameter int MAX_PROBES = 25
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [1:0]                  s_op,
    input  logic [qpht_pkg::KEY_W-1:0]  s_key,
    input  logic [qpht_pkg::SLOT_W-1:0] s_slot,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [1:0]                  m_status,
    output logic [qpht_pkg::SLOT_W-1:0] m_slot_out
);
    import qpht_pkg::*;

    localparam int PCNT_W = $clog2(MAX_PROBES + 1);
    localparam logic [PCNT_W-1:0] LAST_PROBE = PCNT_W'(MAX_PROBES - 1);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HASH,
        ST_CHECK,
        ST_RESP
    } fsm_t;

    fsm_t              state_reg, state_next;
    op_t               op_reg, op_next;
    logic [KEY_W-1:0]  key_reg, key_next;
    logic [SLOT_W-1:0] addr_reg, addr_next;
    logic [SLOT_W-1:0] step_reg, step_next;
    logic [PCNT_W-1:0] probe_cnt_reg, probe_cnt_next;
    logic [SLOT_W-1:0] clr_addr_reg, clr_addr_next;
    status_t           res_status_reg, res_status_next;
    logic [SLOT_W-1:0] res_slot_reg, res_slot_next;
    logic              m_valid_reg, m_valid_next;
    status_t           m_status_reg, m_status_next;
    logic [SLOT_W-1:0] m_slot_out_reg, m_slot_out_next;

    // Table RAM ports
    logic               ram_we;
    logic [SLOT_W-1:0]  ram_waddr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic               ram_re;
    logic [SLOT_W-1:0]  ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;

    // Hash unit
    logic              hash_start;
    logic              hash_done;
    logic [SLOT_W-1:0] hash_home;

    slot_state_t       rd_state;
    logic [KEY_W-1:0]  rd_key;
    logic              last_probe;

    assign rd_state   = slot_state_t'(ram_rdata[ENTRY_W-1 -: STATE_W]);
    assign rd_key     = ram_rdata[KEY_W-1:0];
    assign last_probe = (probe_cnt_reg == LAST_PROBE);

    qpht_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_SIZE)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    qpht_hash u_hash (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (hash_start),
        .key     (s_key),
        .done    (hash_done),
        .home    (hash_home)
    );

    always_comb begin
        state_next      = state_reg;
        op_next         = op_reg;
        key_next        = key_reg;
        addr_next       = addr_reg;
        step_next       = step_reg;
        probe_cnt_next  = probe_cnt_reg;
        clr_addr_next   = clr_addr_reg;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        m_valid_next    = m_valid_reg;
        m_status_next   = m_status_reg;
        m_slot_out_next = m_slot_out_reg;
        ram_we          = 1'b0;
        ram_waddr       = clr_addr_reg;
        ram_wdata       = '0;
        ram_re          = 1'b0;
        ram_raddr       = addr_reg;
        hash_start      = 1'b0;

        // Drop the result once the consumer takes it.
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLEAR: begin
                ram_we        = 1'b1;
                ram_waddr     = clr_addr_reg;
                ram_wdata     = {SLOT_EMPTY, {KEY_W{1'b0}}};
                clr_addr_next = clr_addr_reg + SLOT_W'(1);
                if (clr_addr_reg == SLOT_W'(TABLE_SIZE - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    op_next        = op_t'(s_op);
                    key_next       = s_key;
                    probe_cnt_next = '0;
                    step_next      = STEP_FIRST;
                    unique case (op_t'(s_op))
                        OP_INSERT, OP_FIND: begin
                            hash_start = 1'b1;
                            state_next = ST_HASH;
                        end
                        OP_DELETE: begin
                            // Every 12-bit slot lies inside the table.
                            ram_we          = 1'b1;
                            ram_waddr       = s_slot;
                            ram_wdata       = {SLOT_DEL, {KEY_W{1'b0}}};
                            res_status_next = STATUS_OK;
                            res_slot_next   = s_slot;
                            state_next      = ST_RESP;
                        end
                        default: begin
                            res_status_next = STATUS_MISS;
                            res_slot_next   = '0;
                            state_next      = ST_RESP;
                        end
                    endcase
                end
            end
            ST_HASH: begin
                if (hash_done) begin
                    ram_re     = 1'b1;
                    ram_raddr  = hash_home;
                    addr_next  = hash_home;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (op_reg == OP_INSERT) begin
                    if (rd_state != SLOT_USED) begin
                        ram_we          = 1'b1;
                        ram_waddr       = addr_reg;
                        ram_wdata       = {SLOT_USED, key_reg};
                        res_status_next = STATUS_OK;
                        res_slot_next   = addr_reg;
                        state_next      = ST_RESP;
                    end else if (last_probe) begin
                        res_status_next = STATUS_FULL;
                        res_slot_next   = addr_reg;
                        state_next      = ST_RESP;
                    end
                end else begin
                    if (rd_state == SLOT_USED && rd_key == key_reg) begin
                        res_status_next = STATUS_OK;
                        res_slot_next   = addr_reg;
                        state_next      = ST_RESP;
                    end else if (rd_state == SLOT_EMPTY || last_probe) begin
                        res_status_next = STATUS_MISS;
                        res_slot_next   = '0;
                        state_next      = ST_RESP;
                    end
                end
                // Advance to the next probe and issue its read right away.
                if (state_next == ST_CHECK) begin
                    addr_next      = addr_reg + step_reg;
                    step_next      = step_reg + STEP_INC;
                    probe_cnt_next = probe_cnt_reg + PCNT_W'(1);
                    ram_re         = 1'b1;
                    ram_raddr      = addr_reg + step_reg;
                end
            end
            ST_RESP: begin
                // Hold until the output register is free.
                if (!m_valid_reg || m_ready) begin
                    m_valid_next    = 1'b1;
                    m_status_next   = res_status_reg;
                    m_slot_out_next = res_slot_reg;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            clr_addr_reg  <= '0;
            probe_cnt_reg <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            probe_cnt_reg <= probe_cnt_next;
            m_valid_reg   <= m_valid_next;
        end
        op_reg         <= op_next;
        key_reg        <= key_next;
        addr_reg       <= addr_next;
        step_reg       <= step_next;
        res_status_reg <= res_status_next;
        res_slot_reg   <= res_slot_next;
        m_status_reg   <= m_status_next;
        m_slot_out_reg <= m_slot_out_next;
    end

    assign s_ready    = (state_reg == ST_IDLE);
    assign m_valid    = m_valid_reg;
    assign m_status   = m_status_reg;
    assign m_slot_out = m_slot_out_reg;

    // The probe counter never runs past the last probe.
    a_probe_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        probe_cnt_reg <= LAST_PROBE)
        else $error("probe counter beyond last probe");

    // The hash result arrives only while its walk is waiting for it.
    a_hash_done_in_hash: assert property (@(posedge aclk) disable iff (!aresetn)
        hash_done |-> state_reg == ST_HASH)
        else $error("hash done outside hash state");

    // A table write during the probe walk ends the walk.
    a_write_ends_walk: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CHECK && ram_we) |=> state_reg == ST_RESP)
        else $error("probe walk continued after table write");

    // An insert failure can only come from an insert.
    a_full_from_insert: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CHECK && state_next == ST_RESP &&
         res_status_next == STATUS_FULL) |-> op_reg == OP_INSERT)
        else $error("insert failure on a non-insert item");

endmodule
